// File: hdl/pecf_pkg.sv
// ---------------------------------------------------------------------------
// pecf_pkg: shared types and constants of the terminal pair FIFO block
// Item layouts, operation and status codes, register indexes, controller
// states and the command/status groups between controller and datapath.
// ---------------------------------------------------------------------------
package pecf_pkg;

    localparam int FIFO_DEPTH_DEF = 1024;

    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    localparam logic [2:0] OP_MWRITE = 3'd0;
    localparam logic [2:0] OP_SWRITE = 3'd1;
    localparam logic [2:0] OP_MREAD  = 3'd2;
    localparam logic [2:0] OP_SREAD  = 3'd3;
    localparam logic [2:0] OP_FLUSH  = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_STOP = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRLF = 1'd1;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_in;
        logic       call_last;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_data;
        logic       master_readable;
        logic       slave_readable;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PHASE_A,
        S_PHASE_B,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load_item;
        logic phase_a;
        logic phase_b;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic two_step;
        logic out_busy;
    } dp_status_t;

endpackage

// File: hdl/pty_echo_crlf_fifo_pair_core.sv
// ---------------------------------------------------------------------------
// pty_echo_crlf_fifo_pair_core: terminal pair with echo and CR/LF FIFOs
// Two byte FIFOs (terminal-to-shell, shell-to-terminal) driven one item
// per read/write/flush step.
//
//   channel   ports                          payload
//   ------    -----------------------------  -----------------------
//   input     in_valid / in_stall / in_item  operation, data, last
//   output    out_valid / out_stall / out_item status, byte, readable
//   config    cfg_we / cfg_index / cfg_data  echo, crlf enables
//
// A master write runs two phases when the call is not stopped: the
// shell-to-terminal memory takes the echo and the terminal-to-shell memory the
// carriage return in phase A, and the terminal-to-shell memory takes the byte
// in phase B, each FIFO memory having one write port. Other items, and master
// writes of a stopped call, run phase A only, with the read byte coming from a
// registered memory port.
// Reset clears pointers and fill counts at once; no clearing pass. A stalled
// result holds the next item in its finish step until the output frees up.
// ---------------------------------------------------------------------------
module pty_echo_crlf_fifo_pair_core #(
    parameter int FIFO_DEPTH = pecf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  pecf_pkg::in_item_t               in_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output pecf_pkg::out_item_t              out_item,
    input  logic                             cfg_we,
    input  logic [pecf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                             cfg_data
);

    pecf_pkg::cmd_t       cmd;
    pecf_pkg::dp_status_t dp_status;

    pecf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    pecf_datapath #(.FIFO_DEPTH(FIFO_DEPTH)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .dp_status (dp_status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// File: hdl/pecf_fifo.sv
// ---------------------------------------------------------------------------
// pecf_fifo: byte FIFO with one write and one registered read per cycle
// Circular store with wrap pointers and a fill count; flush resets the
// pointers and the fill count only, the store itself is never cleared.
// ---------------------------------------------------------------------------
module pecf_fifo #(
    parameter int DEPTH = pecf_pkg::FIFO_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clear,
    input  logic       push,
    input  logic [7:0] push_data,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output logic [7:0] rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    rd_data_reg;
    logic          push_ok, pop_ok;

    assign full      = (fill_reg == FW'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign push_ok   = push && !full;
    assign pop_ok    = pop && not_empty;
    assign rd_data   = rd_data_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (clear)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            fill_next   = '0;
        end
        else
        begin
            if (push_ok)
                wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (pop_ok)
                rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (push_ok && !pop_ok)
                fill_next = fill_reg + FW'(1);
            else if (pop_ok && !push_ok)
                fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok && !clear)
            mem[wr_ptr_reg] <= push_data;
        if (pop_ok && !clear)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DEPTH))
        else $error("fifo fill count above depth");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full && !pop && !clear) |=> $stable(fill_reg))
        else $error("push into full fifo changed fill count");

endmodule

// File: hdl/pecf_ctrl.sv
// ---------------------------------------------------------------------------
// pecf_ctrl: item sequencer
// Accept one item, run one or two datapath phases, then load the result
// once the output register is free.
// ---------------------------------------------------------------------------
module pecf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  pecf_pkg::dp_status_t   dp_status,
    output pecf_pkg::cmd_t         cmd
);

    pecf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pecf_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            pecf_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = pecf_pkg::S_PHASE_A;
                end
            end
            pecf_pkg::S_PHASE_A:
            begin
                cmd.phase_a = 1'b1;
                state_next  = dp_status.two_step ? pecf_pkg::S_PHASE_B
                                                 : pecf_pkg::S_FINISH;
            end
            pecf_pkg::S_PHASE_B:
            begin
                cmd.phase_b = 1'b1;
                state_next  = pecf_pkg::S_FINISH;
            end
            pecf_pkg::S_FINISH:
            begin
                // hold the result until the output register frees up
                if (!dp_status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = pecf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pecf_pkg::S_IDLE;
            end
        endcase
    end

    a_b_after_a: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pecf_pkg::S_PHASE_B) |-> $past(state_reg == pecf_pkg::S_PHASE_A))
        else $error("second write phase without first phase");

endmodule

// File: hdl/pecf_datapath.sv
// ---------------------------------------------------------------------------
// pecf_datapath: FIFO pair, configuration and result register
// Decodes the held item into FIFO pushes and pops per phase, tracks the
// stopped-call flag and builds the result item.
// ---------------------------------------------------------------------------
module pecf_datapath #(
    parameter int FIFO_DEPTH = pecf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pecf_pkg::in_item_t               in_item,
    input  logic                             cfg_we,
    input  logic [pecf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                             cfg_data,
    input  pecf_pkg::cmd_t                   cmd,
    output pecf_pkg::dp_status_t             dp_status,
    output logic                             out_valid,
    input  logic                             out_stall,
    output pecf_pkg::out_item_t              out_item
);

    pecf_pkg::in_item_t  item_reg;
    pecf_pkg::out_item_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic                echo_reg, crlf_reg;
    logic                stopped_reg, stopped_next;
    logic [1:0]          res_reg, res_next;

    logic       flush;
    logic       up_push, up_pop, up_full, up_not_empty;
    logic       down_push, down_pop, down_full, down_not_empty;
    logic [7:0] down_data, up_rd, down_rd;
    logic       a_ok;
    logic       is_read;
    logic [2:0] op;

    assign op      = item_reg.operation;
    assign is_read = (op == pecf_pkg::OP_MREAD) || (op == pecf_pkg::OP_SREAD);

    assign dp_status.two_step = (op == pecf_pkg::OP_MWRITE) && !stopped_reg;
    assign dp_status.out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        flush        = 1'b0;
        up_push      = 1'b0;
        up_pop       = 1'b0;
        down_push    = 1'b0;
        down_pop     = 1'b0;
        down_data    = item_reg.data_in;
        a_ok         = 1'b1;
        stopped_next = stopped_reg;
        res_next     = res_reg;
        if (cmd.phase_a)
        begin
            res_next = pecf_pkg::ST_DONE;
            if (!(op inside {pecf_pkg::OP_MWRITE, pecf_pkg::OP_SWRITE,
                             pecf_pkg::OP_MREAD, pecf_pkg::OP_SREAD}))
            begin
                flush        = (op == pecf_pkg::OP_FLUSH);
                stopped_next = 1'b0;
            end
            else if (stopped_reg)
            begin
                res_next = pecf_pkg::ST_SKIP;
                if (item_reg.call_last)
                    stopped_next = 1'b0;
            end
            else
            begin
                case (op)
                    pecf_pkg::OP_MWRITE:
                    begin
                        // echo and carriage return drop silently when full
                        up_push   = echo_reg;
                        down_push = crlf_reg && (item_reg.data_in == pecf_pkg::BYTE_LF);
                        down_data = pecf_pkg::BYTE_CR;
                    end
                    pecf_pkg::OP_SWRITE:
                    begin
                        up_push = 1'b1;
                        a_ok    = !up_full;
                    end
                    pecf_pkg::OP_MREAD:
                    begin
                        up_pop = 1'b1;
                        a_ok   = up_not_empty;
                    end
                    default:
                    begin
                        down_pop = 1'b1;
                        a_ok     = down_not_empty;
                    end
                endcase
                if (!a_ok)
                begin
                    res_next = pecf_pkg::ST_STOP;
                    if (!item_reg.call_last)
                        stopped_next = 1'b1;
                end
            end
        end
        if (cmd.phase_b)
        begin
            down_push = 1'b1;
            if (down_full)
            begin
                res_next = pecf_pkg::ST_STOP;
                if (!item_reg.call_last)
                    stopped_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_next                 = out_reg;
        out_valid_next           = out_valid_reg && out_stall;
        if (cmd.finish)
        begin
            out_valid_next           = 1'b1;
            out_next.status          = res_reg;
            out_next.read_data       = '0;
            if (is_read && (res_reg == pecf_pkg::ST_DONE))
                out_next.read_data = (op == pecf_pkg::OP_MREAD) ? up_rd : down_rd;
            out_next.master_readable = up_not_empty;
            out_next.slave_readable  = down_not_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_reg      <= 1'b1;
            crlf_reg      <= 1'b1;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pecf_pkg::CFG_ECHO: echo_reg <= cfg_data;
                    pecf_pkg::CFG_CRLF: crlf_reg <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_item;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    pecf_fifo #(.DEPTH(FIFO_DEPTH)) u_up_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (flush),
        .push      (up_push),
        .push_data (item_reg.data_in),
        .pop       (up_pop),
        .full      (up_full),
        .not_empty (up_not_empty),
        .rd_data   (up_rd)
    );

    pecf_fifo #(.DEPTH(FIFO_DEPTH)) u_down_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (flush),
        .push      (down_push),
        .push_data (down_data),
        .pop       (down_pop),
        .full      (down_full),
        .not_empty (down_not_empty),
        .rd_data   (down_rd)
    );

    a_stop_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != pecf_pkg::ST_DONE)) |-> (out_reg.read_data == '0))
        else $error("read data nonzero on stopped or skipped item");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a stalled result");

endmodule

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the terminal pair FIFO core
// Drives read, write and flush items through the valid/stall channels,
// tracks both byte FIFOs, the echo and CR/LF settings and the stopped-call
// flag, and checks every result field against the tracked state. Covers
// full and empty FIFOs, dropped echo and carriage-return pushes, skipped
// calls, spare operation codes and all four register settings.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH = pecf_pkg::FIFO_DEPTH_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    class pty_pair_tracker;
        int unsigned         depth;
        logic [7:0]          to_shell[$];   // terminal-to-shell bytes
        logic [7:0]          to_term[$];    // shell-to-terminal bytes
        logic                echo_on;
        logic                crlf_on;
        logic                halted;
        pecf_pkg::out_item_t replies_due[$];
        int                  errors;

        function new(int unsigned fifo_depth);
            depth = fifo_depth;
            echo_on = 1'b1;
            crlf_on = 1'b1;
            halted = 1'b0;
            errors = 0;
        endfunction

        function int shell_fill();
            return to_shell.size();
        endfunction

        function int term_fill();
            return to_term.size();
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void set_reg(logic [pecf_pkg::CFG_IDX_W-1:0] idx, logic val);
            if (idx == pecf_pkg::CFG_ECHO)
                echo_on = val;
            else if (idx == pecf_pkg::CFG_CRLF)
                crlf_on = val;
        endfunction

        // Advance the pair by one item and return the reply it causes.
        function pecf_pkg::out_item_t step_reply(pecf_pkg::in_item_t it);
            pecf_pkg::out_item_t r;
            logic                ok;
            r = '0;
            r.status = pecf_pkg::ST_DONE;
            if (it.operation >= pecf_pkg::OP_FLUSH) begin
                if (it.operation == pecf_pkg::OP_FLUSH) begin
                    to_shell.delete();
                    to_term.delete();
                end
                halted = 1'b0;
            end
            else if (halted) begin
                r.status = pecf_pkg::ST_SKIP;
                if (it.call_last)
                    halted = 1'b0;
            end
            else begin
                ok = 1'b1;
                case (it.operation)
                    pecf_pkg::OP_MWRITE:
                    begin
                        // echo and carriage return go first and drop on full
                        if (echo_on && to_term.size() < depth)
                            to_term.push_back(it.data_in);
                        if (crlf_on && it.data_in == pecf_pkg::BYTE_LF
                            && to_shell.size() < depth)
                            to_shell.push_back(pecf_pkg::BYTE_CR);
                        ok = to_shell.size() < depth;
                        if (ok)
                            to_shell.push_back(it.data_in);
                    end
                    pecf_pkg::OP_SWRITE:
                    begin
                        ok = to_term.size() < depth;
                        if (ok)
                            to_term.push_back(it.data_in);
                    end
                    pecf_pkg::OP_MREAD:
                    begin
                        ok = to_term.size() != 0;
                        if (ok)
                            r.read_data = to_term.pop_front();
                    end
                    pecf_pkg::OP_SREAD:
                    begin
                        ok = to_shell.size() != 0;
                        if (ok)
                            r.read_data = to_shell.pop_front();
                    end
                    default:
                        ok = 1'b1;
                endcase
                if (!ok) begin
                    r.status = pecf_pkg::ST_STOP;
                    r.read_data = 8'h00;
                    if (!it.call_last)
                        halted = 1'b1;
                end
            end
            r.master_readable = to_term.size() != 0;
            r.slave_readable = to_shell.size() != 0;
            return r;
        endfunction

        // Note an accepted item; return 1 if it did real work.
        function logic take_item(pecf_pkg::in_item_t it);
            pecf_pkg::out_item_t r;
            r = step_reply(it);
            replies_due.push_back(r);
            return it.operation <= pecf_pkg::OP_FLUSH && r.status != pecf_pkg::ST_SKIP;
        endfunction

        task report(string what);
            $display("MISMATCH: %s", what);
            errors++;
        endtask

        task match_reply(pecf_pkg::out_item_t got);
            pecf_pkg::out_item_t want;
            if (replies_due.size() == 0) begin
                report($sformatf("result %h with nothing pending", got));
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.read_data !== want.read_data)
                report($sformatf("read_data got %h want %h", got.read_data, want.read_data));
            if (got.master_readable !== want.master_readable)
                report($sformatf("master_readable got %b want %b",
                                 got.master_readable, want.master_readable));
            if (got.slave_readable !== want.slave_readable)
                report($sformatf("slave_readable got %b want %b",
                                 got.slave_readable, want.slave_readable));
        endtask

        task flag_leftovers();
            if (replies_due.size() != 0)
                report($sformatf("%0d results never arrived", replies_due.size()));
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    pecf_pkg::in_item_t             in_item = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    pecf_pkg::out_item_t            out_item;
    logic                           cfg_we = 1'b0;
    logic [pecf_pkg::CFG_IDX_W-1:0] cfg_index = pecf_pkg::CFG_ECHO;
    logic                           cfg_data = 1'b0;

    pty_pair_tracker tracker;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int worked_items = 0;

    pty_echo_crlf_fifo_pair_core #(
        .FIFO_DEPTH(DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Result side: check accepted results, stall in bursts.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                tracker.match_reply(out_item);
            if (stall_left != 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("pty_echo_crlf_fifo_pair_core test failed");
                $finish;
            end
        end
    end

    // Leaves valid high after acceptance so back-to-back items need no gap.
    task automatic send_item(input logic [2:0] op, input logic [7:0] d, input logic last);
        pecf_pkg::in_item_t it;
        int                 gap;
        it.operation = op;
        it.data_in = d;
        it.call_last = last;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (tracker.take_item(it))
            worked_items++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    task automatic set_reg(input logic [pecf_pkg::CFG_IDX_W-1:0] idx, input logic val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_reg(idx, val);
    endtask

    function automatic logic [7:0] pick_byte();
        return ($urandom_range(0, 4) == 0) ? pecf_pkg::BYTE_LF : 8'($urandom);
    endfunction

    task automatic run_calls(input int target);
        int          start;
        int          kind;
        int          len;
        logic [2:0]  op;
        start = worked_items;
        while (worked_items - start < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                case ($urandom_range(0, 3))
                    0: op = pecf_pkg::OP_MWRITE;
                    1: op = pecf_pkg::OP_SWRITE;
                    2: op = pecf_pkg::OP_MREAD;
                    default: op = pecf_pkg::OP_SREAD;
                endcase
                len = $urandom_range(1, 16);
                for (int k = 0; k < len; k++)
                    send_item(op, pick_byte(), k == len - 1);
            end
            else if (kind < 88) begin
                op = ($urandom_range(0, 1) == 0) ? pecf_pkg::OP_FLUSH
                                                 : 3'($urandom_range(OP_SPARE_FIRST,
                                                                     OP_SPARE_LAST));
                send_item(op, 8'($urandom), 1'($urandom));
            end
            else begin
                // noise: any code, any byte, any end mark
                send_item(3'($urandom), 8'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 199) == 0)
                wait_drained();
        end
    endtask

    task automatic fill_and_flush();
        logic [7:0] d;
        // line feeds fill the terminal-to-shell side two bytes at a time
        while (tracker.shell_fill() < DEPTH - 1) begin
            d = (tracker.shell_fill() < DEPTH - 2) ? pecf_pkg::BYTE_LF : 8'h4C;
            send_item(pecf_pkg::OP_MWRITE, d, $urandom_range(0, 15) == 0);
        end
        while (tracker.term_fill() < DEPTH)
            send_item(pecf_pkg::OP_SWRITE, 8'($urandom), $urandom_range(0, 15) == 0);
        // echo dropped, carriage return takes the last slot
        send_item(pecf_pkg::OP_MWRITE, pecf_pkg::BYTE_LF, 1'b0);
        send_item(pecf_pkg::OP_MWRITE, pecf_pkg::BYTE_LF, 1'b1);  // skipped, ends the call
        // both full: echo and return dropped
        send_item(pecf_pkg::OP_MWRITE, pecf_pkg::BYTE_LF, 1'b0);
        send_item(pecf_pkg::OP_SWRITE, 8'h00, 1'b1);
        send_item(pecf_pkg::OP_SWRITE, 8'hFF, 1'b1);    // full on a last byte: no stop carried
        send_item(pecf_pkg::OP_MREAD, 8'h00, 1'b1);
        send_item(pecf_pkg::OP_SREAD, 8'h00, 1'b1);
        send_item(pecf_pkg::OP_FLUSH, 8'h00, 1'b1);
    endtask

    initial begin
        tracker = new(DEPTH);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_reg(pecf_pkg::CFG_ECHO, 1'b1);
        set_reg(pecf_pkg::CFG_CRLF, 1'b1);

        gap_pct = 15;
        stall_pct = 6;
        send_item(pecf_pkg::OP_SREAD, 8'h00, 1'b1);     // empty read on a last byte
        send_item(pecf_pkg::OP_MREAD, 8'h00, 1'b0);     // empty read mid-call: stop
        send_item(pecf_pkg::OP_MWRITE, 8'hFF, 1'b0);    // skipped
        send_item(pecf_pkg::OP_SWRITE, 8'h00, 1'b1);    // skipped, ends the call
        send_item(pecf_pkg::OP_MWRITE, 8'h00, 1'b0);
        send_item(pecf_pkg::OP_MWRITE, 8'hFF, 1'b0);
        send_item(pecf_pkg::OP_MWRITE, pecf_pkg::BYTE_LF, 1'b0);
        send_item(pecf_pkg::OP_MWRITE, pecf_pkg::BYTE_CR, 1'b1);
        send_item(pecf_pkg::OP_SWRITE, 8'h5A, 1'b1);
        send_item(pecf_pkg::OP_MREAD, 8'hFF, 1'b0);
        send_item(pecf_pkg::OP_MREAD, 8'h00, 1'b1);
        send_item(pecf_pkg::OP_SREAD, 8'hFF, 1'b0);
        send_item(pecf_pkg::OP_SREAD, 8'h00, 1'b1);
        send_item(pecf_pkg::OP_FLUSH, 8'hC3, 1'b0);
        send_item(pecf_pkg::OP_MREAD, 8'h00, 1'b0);
        send_item(OP_SPARE_FIRST, 8'hA5, 1'b0);
        send_item(pecf_pkg::OP_SREAD, 8'h00, 1'b0);
        send_item(OP_SPARE_FIRST + 3'd1, 8'h3C, 1'b1);
        send_item(pecf_pkg::OP_SWRITE, 8'h81, 1'b0);
        send_item(OP_SPARE_LAST, 8'h7E, 1'b1);
        send_item(pecf_pkg::OP_MREAD, 8'h00, 1'b0);
        send_item(pecf_pkg::OP_MREAD, 8'h00, 1'b0);     // empty read mid-call: stop
        send_item(pecf_pkg::OP_FLUSH, 8'hFF, 1'b1);
        send_item(pecf_pkg::OP_SWRITE, 8'h81, 1'b1);

        // hold the sender until the pair has answered everything
        wait_drained();
        fill_and_flush();

        set_reg(pecf_pkg::CFG_ECHO, 1'b0);
        set_reg(pecf_pkg::CFG_CRLF, 1'b0);
        gap_pct = 25;
        stall_pct = 10;
        run_calls(55);

        set_reg(pecf_pkg::CFG_ECHO, 1'b1);
        gap_pct = 0;
        stall_pct = 15;
        run_calls(55);

        set_reg(pecf_pkg::CFG_ECHO, 1'b0);
        set_reg(pecf_pkg::CFG_CRLF, 1'b1);
        gap_pct = 30;
        stall_pct = 0;
        run_calls(55);

        set_reg(pecf_pkg::CFG_ECHO, 1'b1);
        gap_pct = 0;
        stall_pct = 0;
        run_calls(55);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        tracker.flag_leftovers();
        if (tracker.errors == 0)
            $display("pty_echo_crlf_fifo_pair_core test passed");
        else
            $display("pty_echo_crlf_fifo_pair_core test failed");
        $finish;
    end
endmodule
